// ----- rtl/battery_charging_state_machine_core_macros.svh -----
// Assertion macros shared by the battery charger state machine checkers.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BATTERY_CHARGING_STATE_MACHINE_CORE_MACROS_SVH
`define BATTERY_CHARGING_STATE_MACHINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define BCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ----- rtl/bcsm_pkg.sv -----
// Package for the battery charger state machine: state, request and reason codes,
// the charger type count, a kind check and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package bcsm_pkg;

    localparam int unsigned CHARGER_TYPES = 8;

    localparam logic [2:0] ST_DISCHG   = 3'd0;
    localparam logic [2:0] ST_CHG      = 3'd1;
    localparam logic [2:0] ST_STOP     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_KEEP     = 3'd4;
    localparam logic [2:0] ST_KEEPSTOP = 3'd5;

    localparam logic [1:0] REQ_CABLE  = 2'd0;
    localparam logic [1:0] REQ_STOP   = 2'd1;
    localparam logic [1:0] REQ_RESUME = 2'd2;
    localparam logic [1:0] REQ_DROP   = 2'd3;

    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] RSN_NONE    = 4'd0;
    localparam logic [3:0] RSN_DONE    = 4'd1;
    localparam logic [3:0] RSN_BANK    = 4'd2;
    localparam logic [3:0] RSN_BALANCE = 4'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] charger_kind;
        logic [3:0] stop_reason;
    } event_t;

    typedef struct packed {
        logic [2:0] charge_state;
        logic [3:0] active_charger;
        logic [3:0] last_reason;
    } status_t;

    typedef struct packed {
        status_t    status;
        logic       state_changed;
    } result_t;

    function automatic logic kind_valid(input logic [3:0] kind);
        return (kind != KIND_NONE) && ({1'b0, kind} < 5'(CHARGER_TYPES));
    endfunction

endpackage

// ----- rtl/bcsm_transition.sv -----
// Transition logic of the charger state machine: one event and the current
// status in, the status after the event and a changed flag out. Uses bcsm_pkg.
`timescale 1ns / 1ps

module bcsm_transition (
    input  bcsm_pkg::status_t cur,
    input  bcsm_pkg::event_t  ev,
    input  logic              charge_mode_enabled,
    output bcsm_pkg::result_t res
);

    logic ev_out;
    logic ev_in;
    logic ev_done;
    logic ev_stop;
    logic ev_resume;
    logic ev_drop;
    logic bank;
    logic chg_valid;

    always_comb
    begin
        ev_out    = (ev.req_type == bcsm_pkg::REQ_CABLE) &&
                    (ev.charger_kind == bcsm_pkg::KIND_NONE);
        ev_in     = (ev.req_type == bcsm_pkg::REQ_CABLE) &&
                    bcsm_pkg::kind_valid(ev.charger_kind);
        ev_done   = (ev.req_type == bcsm_pkg::REQ_STOP) &&
                    (ev.stop_reason == bcsm_pkg::RSN_DONE);
        ev_stop   = (ev.req_type == bcsm_pkg::REQ_STOP) &&
                    (ev.stop_reason != bcsm_pkg::RSN_DONE);
        ev_resume = (ev.req_type == bcsm_pkg::REQ_RESUME);
        ev_drop   = (ev.req_type == bcsm_pkg::REQ_DROP);
        bank      = (ev.stop_reason == bcsm_pkg::RSN_BANK) ||
                    (ev.stop_reason == bcsm_pkg::RSN_BALANCE);
        chg_valid = bcsm_pkg::kind_valid(cur.active_charger);
    end

    always_comb
    begin
        res.status        = cur;
        res.state_changed = 1'b0;
        unique case (cur.charge_state)
            bcsm_pkg::ST_DISCHG:
            begin
                if (ev_in)
                begin
                    res.status = '{bcsm_pkg::ST_CHG, ev.charger_kind, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
            end
            bcsm_pkg::ST_CHG:
            begin
                if (ev_out)
                begin
                    res.status = '{bcsm_pkg::ST_DISCHG, bcsm_pkg::KIND_NONE,
                                   bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_done)
                begin
                    res.status = '{bcsm_pkg::ST_FULL, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_stop)
                begin
                    res.status = '{bcsm_pkg::ST_STOP, cur.active_charger, ev.stop_reason};
                    res.state_changed = 1'b1;
                end
                else if (ev_in && charge_mode_enabled)
                begin
                    res.status = '{bcsm_pkg::ST_CHG, ev.charger_kind, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
            end
            bcsm_pkg::ST_STOP:
            begin
                if (ev_out)
                begin
                    res.status = '{bcsm_pkg::ST_DISCHG, bcsm_pkg::KIND_NONE,
                                   bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_resume)
                begin
                    res.status = '{bcsm_pkg::ST_CHG, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
            end
            bcsm_pkg::ST_FULL, bcsm_pkg::ST_KEEPSTOP:
            begin
                if (ev_out)
                begin
                    res.status = '{bcsm_pkg::ST_DISCHG, bcsm_pkg::KIND_NONE,
                                   bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_resume)
                begin
                    res.status = '{bcsm_pkg::ST_KEEP, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_stop && bank)
                begin
                    res.status = '{bcsm_pkg::ST_STOP, cur.active_charger, ev.stop_reason};
                    res.state_changed = 1'b1;
                end
                else if (ev_drop && chg_valid)
                begin
                    res.status = '{bcsm_pkg::ST_CHG, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
            end
            bcsm_pkg::ST_KEEP:
            begin
                if (ev_out)
                begin
                    res.status = '{bcsm_pkg::ST_DISCHG, bcsm_pkg::KIND_NONE,
                                   bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_done)
                begin
                    res.status = '{bcsm_pkg::ST_FULL, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
                else if (ev_stop)
                begin
                    res.status = '{(bank ? bcsm_pkg::ST_STOP : bcsm_pkg::ST_KEEPSTOP),
                                   cur.active_charger, ev.stop_reason};
                    res.state_changed = 1'b1;
                end
                else if (ev_drop && chg_valid)
                begin
                    res.status = '{bcsm_pkg::ST_CHG, cur.active_charger, bcsm_pkg::RSN_NONE};
                    res.state_changed = 1'b1;
                end
            end
            default:
            begin
                res.status        = cur;
                res.state_changed = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/battery_charging_state_machine_core.sv -----
// Battery charger state machine: one event per cycle while the output is not stalled.
// The event is registered, decoded against the stored state, which updates the
// state registers, and the result goes to an output register; the block can take
// a new event while the previous result waits in the output register.
// The charge mode register is written through cfg_wr_en and cfg_wr_data.
// Top level; uses bcsm_pkg and bcsm_transition.
`timescale 1ns / 1ps

module battery_charging_state_machine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // charger_kind[3:0], stop_reason[7:4]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // charge_state, active_charger, last_reason,
                                   // state_changed, zero padding
);

    logic               mode_reg;
    logic               in_valid_reg;
    bcsm_pkg::event_t   in_event_reg;
    bcsm_pkg::status_t  status_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic               advance;
    logic               fire;
    bcsm_pkg::result_t  res;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bcsm_transition u_transition (
        .cur                 (status_reg),
        .ev                  (in_event_reg),
        .charge_mode_enabled (mode_reg),
        .res                 (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '{bcsm_pkg::ST_DISCHG, bcsm_pkg::KIND_NONE, bcsm_pkg::RSN_NONE};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                status_reg <= res.status;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_event_reg <= '{s_tuser, s_tdata[3:0], s_tdata[7:4]};
        end
        if (fire)
        begin
            out_data_reg <= {4'b0000, res.state_changed, res.status.last_reason,
                             res.status.active_charger, res.status.charge_state};
        end
    end

endmodule

// ----- rtl/bcsm_checker.sv -----
// Port-level checks for the battery charger state machine, bound to the top level.
// Uses bcsm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "battery_charging_state_machine_core_macros.svh"

module bcsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [2:0] st;
    logic       held;
    logic       dischg_shown;
    logic       no_reason_shown;

    assign st              = m_tdata[2:0];
    assign held            = m_tvalid && !m_tready;
    assign dischg_shown    = m_tvalid && (st == bcsm_pkg::ST_DISCHG);
    assign no_reason_shown = m_tvalid && ((st == bcsm_pkg::ST_CHG) ||
                                          (st == bcsm_pkg::ST_FULL) ||
                                          (st == bcsm_pkg::ST_KEEP));

    `BCSM_ASSERT_NEXT(a_result_held, clk, rst_n, held, m_tvalid && $stable(m_tdata))
    `BCSM_ASSERT_SAME(a_state_legal, clk, rst_n, m_tvalid, (st != 3'd6) && (st != 3'd7))
    `BCSM_ASSERT_SAME(a_dischg_clear, clk, rst_n, dischg_shown, m_tdata[10:3] == 8'd0)
    `BCSM_ASSERT_SAME(a_no_reason, clk, rst_n, no_reason_shown, m_tdata[10:7] == bcsm_pkg::RSN_NONE)
    `BCSM_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_tready, m_tvalid)

endmodule

bind battery_charging_state_machine_core bcsm_checker u_bcsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
